FILE: rtl/kvfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvfe_pkg
// Types and constants shared by the keyed value field extractor.
// ----------------------------------------------------------------------------
package kvfe_pkg;

	localparam int KEY_W    = 64;
	localparam int KLEN_W   = 4;
	localparam int VLEN_W   = 6;
	localparam int CHAR_W   = 8;
	localparam int CIDX_W   = 2;
	localparam int SEEN_MAX = 15;

	localparam logic [VLEN_W-1:0] MAX_VALUE_CHARS = 6'd63;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;

	localparam logic [CIDX_W-1:0] REG_KEY_CHARS     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_KEY_LENGTH    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_VALUE_LEN = 2'd2;

	localparam logic [KEY_W-1:0]  KEY_CHARS_RST     = '0;
	localparam logic [KLEN_W-1:0] KEY_LENGTH_RST    = 4'd1;
	localparam logic [VLEN_W-1:0] MAX_VALUE_LEN_RST = 6'd63;

	typedef enum logic [2:0] {
		MODE_SEARCHING  = 3'b001,
		MODE_EXTRACTING = 3'b010,
		MODE_SKIPPING   = 3'b100
	} mode_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_chars;
		logic [KLEN_W-1:0] key_length;
		logic [VLEN_W-1:0] max_value_length;
	} cfg_t;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              end_of_string;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] value_char;
		logic              char_valid;
		logic              done_res;
		logic              found;
	} res_t;

endpackage

FILE: rtl/kvfe_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvfe_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface kvfe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kvfe_pkg::CIDX_W-1:0]   index;
	logic [kvfe_pkg::KEY_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/kvfe_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvfe_item_if
// Input byte channel: one string byte and its end flag per request.
// ----------------------------------------------------------------------------
interface kvfe_item_if;
	logic                          valid;
	logic                          ready;
	logic [kvfe_pkg::CHAR_W-1:0]   in_char;
	logic                          end_of_string;

	modport source (output valid, output in_char, output end_of_string, input ready);
	modport sink   (input valid, input in_char, input end_of_string, output ready);
endinterface

FILE: rtl/kvfe_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvfe_result_if
// Result channel: value byte and done status per request.
// ----------------------------------------------------------------------------
interface kvfe_result_if;
	logic                          valid;
	logic                          ready;
	logic [kvfe_pkg::CHAR_W-1:0]   value_char;
	logic                          char_valid;
	logic                          done_res;
	logic                          found;

	modport source (output valid, output value_char, output char_valid, output done_res,
		output found, input ready);
	modport sink   (input valid, input value_char, input char_valid, input done_res,
		input found, output ready);
endinterface

FILE: rtl/kvfe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvfe_cfg_regs
// Configuration registers: key bytes, key length and value length limit.
// ----------------------------------------------------------------------------
module kvfe_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	kvfe_cfg_if.sink              cfg,
	output kvfe_pkg::cfg_t        regs
);

	kvfe_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.key_chars        <= kvfe_pkg::KEY_CHARS_RST;
			regs_q.key_length       <= kvfe_pkg::KEY_LENGTH_RST;
			regs_q.max_value_length <= kvfe_pkg::MAX_VALUE_LEN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				kvfe_pkg::REG_KEY_CHARS: begin
					regs_q.key_chars <= cfg.data;
				end
				kvfe_pkg::REG_KEY_LENGTH: begin
					regs_q.key_length <= cfg.data[kvfe_pkg::KLEN_W-1:0];
				end
				kvfe_pkg::REG_MAX_VALUE_LEN: begin
					regs_q.max_value_length <= cfg.data[kvfe_pkg::VLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/kvfe_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvfe_scan
// String scanner: recent byte window, parallel key compare, mode and value
// counter; forms the result for one byte and updates state on each step.
// ----------------------------------------------------------------------------
module kvfe_scan #(
	parameter int MAX_KEY_CHARS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kvfe_pkg::cfg_t  regs,
	input  logic            step,
	input  kvfe_pkg::item_t item,
	output kvfe_pkg::res_t  res,
	output logic            res_valid
);

	localparam int WIN_D = MAX_KEY_CHARS + 1;

	logic [kvfe_pkg::CHAR_W-1:0] window_q [WIN_D];
	logic [kvfe_pkg::CHAR_W-1:0] window_n [WIN_D];
	logic [kvfe_pkg::KLEN_W-1:0] seen_q, seen_n;
	kvfe_pkg::mode_t             mode_q, mode_n;
	logic [kvfe_pkg::VLEN_W-1:0] vcount_q, vcount_n;

	logic [kvfe_pkg::KLEN_W-1:0] eff_len;
	logic [kvfe_pkg::VLEN_W-1:0] limit;
	logic [MAX_KEY_CHARS:1]      len_match;
	logic [MAX_KEY_CHARS:1]      len_sel;
	logic                        key_hit;
	logic                        shift;
	logic                        last;
	logic [kvfe_pkg::CHAR_W-1:0] c;

	assign c    = item.in_char;
	assign last = item.end_of_string;

	// key length clamp and value limit
	always_comb begin
		if (regs.key_length == '0) begin
			eff_len = kvfe_pkg::KLEN_W'(1);
		end else if (regs.key_length > kvfe_pkg::KLEN_W'(MAX_KEY_CHARS)) begin
			eff_len = kvfe_pkg::KLEN_W'(MAX_KEY_CHARS);
		end else begin
			eff_len = regs.key_length;
		end
		if (regs.max_value_length > kvfe_pkg::MAX_VALUE_CHARS) begin
			limit = kvfe_pkg::MAX_VALUE_CHARS;
		end else begin
			limit = regs.max_value_length;
		end
	end

	// one compare per candidate key length
	for (genvar l = 1; l <= MAX_KEY_CHARS; l++) begin : g_len
		logic [l-1:0] byte_eq;
		for (genvar i = 0; i < l; i++) begin : g_byte
			assign byte_eq[i] = (window_q[l-1-i] == regs.key_chars[8*i +: 8]);
		end
		assign len_sel[l]   = (eff_len == kvfe_pkg::KLEN_W'(l));
		assign len_match[l] = (&byte_eq) && (seen_q >= kvfe_pkg::KLEN_W'(l)) &&
			((seen_q == kvfe_pkg::KLEN_W'(l)) || (window_q[l] == kvfe_pkg::CHAR_SPACE) ||
			(window_q[l] == kvfe_pkg::CHAR_SEMI));
	end

	assign key_hit = |(len_match & len_sel);

	always_comb begin
		res      = '0;
		mode_n   = mode_q;
		vcount_n = vcount_q;
		shift    = 1'b0;
		case (mode_q)
			kvfe_pkg::MODE_SEARCHING: begin
				if ((c == kvfe_pkg::CHAR_SPACE) && key_hit) begin
					mode_n   = kvfe_pkg::MODE_EXTRACTING;
					vcount_n = '0;
					if (last) begin
						res.done_res = 1'b1;
						res.found    = 1'b1;
					end
				end else begin
					shift = 1'b1;
					if (last) begin
						res.done_res = 1'b1;
					end
				end
			end
			kvfe_pkg::MODE_EXTRACTING: begin
				if (c == kvfe_pkg::CHAR_SEMI) begin
					res.done_res = 1'b1;
					res.found    = 1'b1;
					mode_n       = kvfe_pkg::MODE_SKIPPING;
				end else begin
					if (vcount_q < limit) begin
						res.value_char = c;
						res.char_valid = 1'b1;
						vcount_n       = vcount_q + kvfe_pkg::VLEN_W'(1);
					end
					if (last) begin
						res.done_res = 1'b1;
						res.found    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// window shift
		for (int k = 0; k < WIN_D; k++) begin
			window_n[k] = window_q[k];
		end
		seen_n = seen_q;
		if (shift) begin
			window_n[0] = c;
			for (int k = 1; k < WIN_D; k++) begin
				window_n[k] = window_q[k-1];
			end
			if (seen_q != kvfe_pkg::KLEN_W'(kvfe_pkg::SEEN_MAX)) begin
				seen_n = seen_q + kvfe_pkg::KLEN_W'(1);
			end
		end

		// end of string clears everything
		if (last) begin
			for (int k = 0; k < WIN_D; k++) begin
				window_n[k] = '0;
			end
			seen_n   = '0;
			mode_n   = kvfe_pkg::MODE_SEARCHING;
			vcount_n = '0;
		end
	end

	assign res_valid = res.char_valid | res.done_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_D; k++) begin
				window_q[k] <= '0;
			end
			seen_q   <= '0;
			mode_q   <= kvfe_pkg::MODE_SEARCHING;
			vcount_q <= '0;
		end else if (step) begin
			for (int k = 0; k < WIN_D; k++) begin
				window_q[k] <= window_n[k];
			end
			seen_q   <= seen_n;
			mode_q   <= mode_n;
			vcount_q <= vcount_n;
		end
	end

endmodule

FILE: rtl/keyed_value_field_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_value_field_extractor_core
// Path: an accepted byte passes the input register, then the scan logic into the
// result register, which holds its result until the result side is ready.
// Throughput: one byte per cycle while the result side is ready; the window compare is combinational.
// Reset: arst_n clears valid flags, config and string state (data registers are not reset); no clearing pass.
// ----------------------------------------------------------------------------
module keyed_value_field_extractor_core #(
	parameter int MAX_KEY_CHARS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	kvfe_cfg_if.sink       cfg,
	kvfe_item_if.sink      item,
	kvfe_result_if.source  result
);

	kvfe_pkg::cfg_t  regs;
	kvfe_pkg::item_t item_s1;
	logic            valid_s1;
	kvfe_pkg::res_t  scan_res;
	logic            scan_res_valid;
	kvfe_pkg::res_t  res_q;
	logic            res_valid_q;
	logic            advance;

	kvfe_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.in_char       <= item.in_char;
			item_s1.end_of_string <= item.end_of_string;
		end
	end

	kvfe_scan #(
		.MAX_KEY_CHARS (MAX_KEY_CHARS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.step      (advance),
		.item      (item_s1),
		.res       (scan_res),
		.res_valid (scan_res_valid)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= scan_res_valid;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= scan_res;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.value_char = res_q.value_char;
	assign result.char_valid = res_q.char_valid;
	assign result.done_res   = res_q.done_res;
	assign result.found      = res_q.found;

endmodule
